@@ src/rks_pkg.sv @@
package rks_pkg;

    localparam int EST_FRAC_BITS = 8;
    localparam int VAR_FRAC_BITS = 16;

    localparam int SAMPLE_W = 8;
    localparam int EST_W    = 16;
    localparam int VAR_W    = 24;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

    localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = 24'd66;
    localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 24'd6554;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

endpackage

@@ src/rks_ser_mul.sv @@
module rks_ser_mul #(
    parameter int MW = 24,
    parameter int NB = 17
) (
    input  logic                 i_clk,
    input  rks_pkg::t_mul_ctl    i_ctl,
    input  logic [MW-1:0]        i_mcand,
    input  logic [NB-1:0]        i_mplier,
    output logic [MW+NB-1:0]     o_prod
);

    logic [MW+NB-1:0] r_acc;
    logic [MW-1:0]    r_mcand;
    logic [NB-1:0]    r_bits;
    logic [MW:0]      n_sum;

    // lsb-first shift-add, one multiplier bit per step
    assign n_sum = {1'b0, r_acc[MW+NB-1:NB]} + (r_bits[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc   <= '0;
            r_mcand <= i_mcand;
            r_bits  <= i_mplier;
        end else if (i_ctl.step) begin
            r_acc  <= {n_sum, r_acc[NB-1:1]};
            r_bits <= r_bits >> 1;
        end
    end

    assign o_prod = r_acc;

endmodule

@@ src/rssi_kalman_smoother.sv @@
// channel   direction  handshake          payload
// sample    in         i_valid / o_stall  i_sample_dbm   (signed 8, whole dBm)
// smoothed  out        o_valid / i_stall  o_smoothed_dbm (signed Q8.8)
// config    in         i_cfg_we           i_cfg_index, i_cfg_data (24 bits)
//
// one sample runs from accept to a valid result through the prior, denominator, divide,
// multiply, round and commit steps, using the bit-serial divider and the bit-serial multipliers
// the next sample is taken the cycle after the previous result lands in the output register;
// a result held under i_stall does not block it, a finished result waits in the last step
// i_rst_n is synchronous, active low: it holds o_stall high, clears estimate and variance
// and loads the noise registers with their defaults
module rssi_kalman_smoother #(
    parameter int EST_FRAC_BITS = rks_pkg::EST_FRAC_BITS,
    parameter int VAR_FRAC_BITS = rks_pkg::VAR_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rks_pkg::SAMPLE_W-1:0] i_sample_dbm,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rks_pkg::EST_W-1:0]    o_smoothed_dbm,
    input  logic                                i_cfg_we,
    input  logic [rks_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rks_pkg::VAR_W-1:0]           i_cfg_data
);

    localparam int VW   = rks_pkg::VAR_W;
    localparam int EW   = rks_pkg::EST_W;
    localparam int SW   = rks_pkg::SAMPLE_W;
    localparam int F    = VAR_FRAC_BITS;
    localparam int GW   = F + 1;
    localparam int DW   = VW + 1;
    localparam int NW   = VW + F + 1;
    localparam int IW   = ((SW + EST_FRAC_BITS > EW) ? SW + EST_FRAC_BITS : EW) + 1;
    localparam int P1W  = IW + GW;
    localparam int P2W  = VW + GW;
    localparam int DMW  = P1W + 1 - F;
    localparam int DLW  = DMW + 1;
    localparam int SUMW = ((DLW > EW) ? DLW : EW) + 1;
    localparam int VNW  = P2W + 1 - F;
    localparam int CW   = $clog2(GW);

    localparam logic [GW-1:0] GAIN_ONE = {1'b1, {F{1'b0}}};
    localparam logic [P1W:0]  P1_HALF  = {{(P1W + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [P2W:0]  P2_HALF  = {{(P2W + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [EW-1:0] EST_HI = {1'b0, {(EW - 1){1'b1}}};
    localparam logic signed [EW-1:0] EST_LO = {1'b1, {(EW - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIOR,
        S_DENOM,
        S_PREP,
        S_DIV,
        S_LOAD,
        S_MUL,
        S_ROUND,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [VW-1:0]         r_pn;
    logic [VW-1:0]         r_mn;
    logic [VW-1:0]         r_var;
    logic [VW-1:0]         r_prior;
    logic signed [EW-1:0]  r_est;
    logic signed [EW-1:0]  r_out_smoothed;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_sample;
    logic                  r_innov_neg;
    logic [IW-1:0]         r_mag;
    logic [DW-1:0]         r_denom;
    logic [DW-1:0]         r_rem;
    logic [GW-1:0]         r_nbits;
    logic [GW-1:0]         r_q;
    logic                  r_dzero;
    logic [CW-1:0]         r_cnt;
    logic signed [EW-1:0]  r_est_new;
    logic [VW-1:0]         r_var_new;

    logic [VW:0]           n_psum;
    logic [VW-1:0]         n_prior;
    logic signed [IW-1:0]  n_scaled;
    logic signed [IW-1:0]  n_innov;
    logic [IW-1:0]         n_mag;
    logic [DW-1:0]         n_denom;
    logic [NW-1:0]         n_num;
    logic [DW:0]           n_trial;
    logic [DW:0]           n_diff;
    logic                  n_ge;
    logic [DW-1:0]         n_rem;
    logic [GW-1:0]         n_gain;
    logic [GW-1:0]         n_ngain;
    logic [DMW-1:0]        n_dmag;
    logic signed [DLW-1:0] n_delta;
    logic signed [SUMW-1:0] n_esum;
    logic signed [EW-1:0]  n_est_sat;
    logic [VNW-1:0]        n_vfull;
    logic [VW-1:0]         n_var_sat;
    logic                  n_commit;
    logic                  n_last;

    rks_pkg::t_mul_ctl     w_mul_ctl;
    logic [P1W-1:0]        w_prod_delta;
    logic [P2W-1:0]        w_prod_var;

    // prior variance and innovation
    assign n_psum   = {1'b0, r_var} + {1'b0, r_pn};
    assign n_prior  = n_psum[VW] ? '1 : n_psum[VW-1:0];
    assign n_scaled = IW'(r_sample) <<< EST_FRAC_BITS;
    assign n_innov  = n_scaled - IW'(r_est);
    assign n_mag    = n_innov[IW-1] ? IW'(-n_innov) : IW'(n_innov);

    // gain numerator carries the half-divisor for round to nearest
    assign n_denom = {1'b0, r_prior} + DW'(r_mn);
    assign n_num   = {1'b0, r_prior, {F{1'b0}}} + NW'(r_denom >> 1);

    // restoring divide, one quotient bit per cycle
    assign n_trial = {r_rem, r_nbits[GW-1]};
    assign n_ge    = n_trial >= {1'b0, r_denom};
    assign n_diff  = n_trial - {1'b0, r_denom};
    assign n_rem   = n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];

    assign n_gain  = r_dzero ? '0 : r_q;
    assign n_ngain = GAIN_ONE - n_gain;

    assign w_mul_ctl.load = (r_state == S_LOAD);
    assign w_mul_ctl.step = (r_state == S_MUL);

    rks_ser_mul #(
        .MW (IW),
        .NB (GW)
    ) u_mul_delta (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (r_mag),
        .i_mplier (n_gain),
        .o_prod   (w_prod_delta)
    );

    rks_ser_mul #(
        .MW (VW),
        .NB (GW)
    ) u_mul_var (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (r_prior),
        .i_mplier (n_ngain),
        .o_prod   (w_prod_var)
    );

    // delta rounds half away from zero by rounding the magnitude
    assign n_dmag  = DMW'(({1'b0, w_prod_delta} + P1_HALF) >> F);
    assign n_delta = r_innov_neg ? -$signed({1'b0, n_dmag}) : $signed({1'b0, n_dmag});
    assign n_esum  = SUMW'(r_est) + SUMW'(n_delta);

    always_comb begin
        if ((n_esum[SUMW-1:EW-1] == '0) || (n_esum[SUMW-1:EW-1] == '1)) begin
            n_est_sat = n_esum[EW-1:0];
        end else if (n_esum[SUMW-1]) begin
            n_est_sat = EST_LO;
        end else begin
            n_est_sat = EST_HI;
        end
    end

    assign n_vfull   = VNW'(({1'b0, w_prod_var} + P2_HALF) >> F);
    assign n_var_sat = (|n_vfull[VNW-1:VW]) ? '1 : n_vfull[VW-1:0];

    assign n_commit = (r_state == S_FIN) && (!r_out_valid || !i_stall);
    assign n_last   = (r_cnt == CW'(GW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pn        <= rks_pkg::PROCESS_NOISE_RST;
            r_mn        <= rks_pkg::MEASUREMENT_NOISE_RST;
            r_var       <= '0;
            r_est       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rks_pkg::CFG_PROCESS_NOISE) begin
                    r_pn <= i_cfg_data;
                end else if (i_cfg_index == rks_pkg::CFG_MEASUREMENT_NOISE) begin
                    r_mn <= i_cfg_data;
                end
            end

            if (n_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample_dbm;
                        r_state  <= S_PRIOR;
                    end
                end
                S_PRIOR: begin
                    r_prior     <= n_prior;
                    r_innov_neg <= n_innov[IW-1];
                    r_mag       <= n_mag;
                    r_state     <= S_DENOM;
                end
                S_DENOM: begin
                    r_denom <= n_denom;
                    r_dzero <= (n_denom == '0);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_rem   <= DW'(n_num[NW-1:GW]);
                    r_nbits <= n_num[GW-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= n_rem;
                    r_nbits <= r_nbits << 1;
                    r_q     <= {r_q[GW-2:0], n_ge};
                    if (n_last) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_LOAD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (n_last) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_ROUND: begin
                    r_est_new <= n_est_sat;
                    r_var_new <= n_var_sat;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (n_commit) begin
                        r_est          <= r_est_new;
                        r_var          <= r_var_new;
                        r_out_smoothed <= r_est_new;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = !i_rst_n || (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_smoothed_dbm = r_out_smoothed;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_PRIOR))
        else $error("accepted transaction did not start the update");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !r_dzero) |-> (r_rem < r_denom))
        else $error("divider remainder not below divisor");

    a_var_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_var_new <= r_prior))
        else $error("posterior variance above prior");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && i_stall)
            |=> (r_state == S_FIN && o_valid && $stable(o_smoothed_dbm)))
        else $error("pending result overwritten");

endmodule

@@ dv/rks_checker.sv @@
`timescale 1ns / 1ps

module rks_checker
    import rks_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic signed [SAMPLE_W-1:0]  i_sample_dbm,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic signed [EST_W-1:0]     o_smoothed_dbm,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [VAR_W-1:0]            i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    localparam longint unsigned UNITY   = 64'd1 << VAR_FRAC_BITS;
    localparam longint unsigned VAR_SAT = (64'd1 << VAR_W) - 1;
    localparam longint          EST_MAX = (64'sd1 <<< (EST_W - 1)) - 1;
    localparam longint          EST_MIN = -EST_MAX - 1;

    logic [VAR_W-1:0]        proc_noise = PROCESS_NOISE_RST;
    logic [VAR_W-1:0]        meas_noise = MEASUREMENT_NOISE_RST;
    logic [VAR_W-1:0]        err_var    = '0;
    logic signed [EST_W-1:0] est_q88    = '0;
    logic signed [EST_W-1:0] smoothed_expected[$];
    logic signed [EST_W-1:0] want;

    int fail_count      = 0;
    int results_checked = 0;
    int pending         = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = results_checked;
    assign o_pending    = pending;

    // one filter step: advances the tracked estimate and variance, returns the new estimate
    function automatic logic signed [EST_W-1:0] kalman_update(
        input logic signed [SAMPLE_W-1:0] sample
    );
        longint unsigned prior, denom, gain, var_next;
        longint          innov, weighted, mag, est_next;
        prior = 64'(err_var) + 64'(proc_noise);
        if (prior > VAR_SAT) prior = VAR_SAT;
        denom = prior + 64'(meas_noise);
        // zero divisor only when prior and measurement noise are both zero
        if (denom == 0) gain = 0;
        else gain = ((prior << VAR_FRAC_BITS) + denom / 2) / denom;
        if (gain > UNITY) gain = UNITY;
        innov    = (longint'(sample) <<< EST_FRAC_BITS) - longint'(est_q88);
        weighted = longint'(gain) * innov;
        // round half away from zero on the magnitude
        mag      = (weighted < 0) ? -weighted : weighted;
        mag      = (mag + (64'sd1 <<< (VAR_FRAC_BITS - 1))) >>> VAR_FRAC_BITS;
        est_next = longint'(est_q88) + ((weighted < 0) ? -mag : mag);
        if (est_next > EST_MAX) est_next = EST_MAX;
        if (est_next < EST_MIN) est_next = EST_MIN;
        var_next = ((UNITY - gain) * prior + (UNITY >> 1)) >> VAR_FRAC_BITS;
        if (var_next > VAR_SAT) var_next = VAR_SAT;
        est_q88 = est_next[EST_W-1:0];
        err_var = var_next[VAR_W-1:0];
        return est_q88;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            proc_noise = PROCESS_NOISE_RST;
            meas_noise = MEASUREMENT_NOISE_RST;
            err_var    = '0;
            est_q88    = '0;
            smoothed_expected.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (smoothed_expected.size() == 0) begin
                    $error("smoothed_dbm: unexpected transaction, expected none, actual %0d",
                           o_smoothed_dbm);
                    fail_count <= fail_count + 1;
                end else begin
                    want = smoothed_expected.pop_front();
                    results_checked <= results_checked + 1;
                    if (o_smoothed_dbm !== want) begin
                        $error("smoothed_dbm mismatch: expected %0d, actual %0d",
                               want, o_smoothed_dbm);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE:     proc_noise = i_cfg_data;
                    CFG_MEASUREMENT_NOISE: meas_noise = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                smoothed_expected.push_back(kalman_update(i_sample_dbm));
            end
        end
        pending <= smoothed_expected.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rks_pkg::*;

    localparam int              PHASES       = 12;
    localparam int              PHASE_ITEMS  = 150;
    localparam int              RUN_LIMIT_NS = 8_000_000;
    localparam logic [VAR_W-1:0] NOISE_MAX   = {VAR_W{1'b1}};

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample_dbm = '0;
    logic                       o_valid;
    logic                       i_stall      = 1'b0;
    logic signed [EST_W-1:0]    o_smoothed_dbm;
    logic                       i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index  = CFG_PROCESS_NOISE;
    logic [VAR_W-1:0]           i_cfg_data   = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int samples_sent  = 0;
    int noise_sets    = 0;
    int fail_count;
    int pending;
    int checked;

    rssi_kalman_smoother i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_dbm   (i_sample_dbm),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_smoothed_dbm (o_smoothed_dbm),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    rks_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_dbm   (i_sample_dbm),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_smoothed_dbm (o_smoothed_dbm),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // called and returns at a falling edge; valid stays up until the transaction is taken
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sample_dbm <= sample;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_noise(input logic [VAR_W-1:0] q, input logic [VAR_W-1:0] r);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PROCESS_NOISE;
        i_cfg_data  <= q;
        @(negedge i_clk);
        i_cfg_index <= CFG_MEASUREMENT_NOISE;
        i_cfg_data  <= r;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        noise_sets++;
    endtask

    function automatic logic [VAR_W-1:0] pick_noise();
        case ($urandom_range(5))
            0:       return '0;
            1:       return VAR_W'(1);
            2:       return NOISE_MAX;
            3:       return VAR_W'($urandom_range(255, 1));
            4:       return VAR_W'($urandom_range(65535, 1));
            default: return VAR_W'($urandom);
        endcase
    endfunction

    // half full-range noise, half a wandering signal level with jitter
    task automatic random_samples(input int count);
        int level;
        int v;
        level = -int'($urandom_range(100, 30));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1)) begin
                v = int'($signed(SAMPLE_W'($urandom)));
            end else begin
                level = level + int'($urandom_range(4)) - 2;
                if (level < -110) level = -110;
                if (level > -20) level = -20;
                v = level + int'($urandom_range(12)) - 6;
            end
            send_sample(SAMPLE_W'(v));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default noise settings
        send_sample(-128);
        send_sample(127);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(64);
        send_sample(-64);
        send_sample(5);

        // saturated prior with zero measurement noise: gain of one, estimate follows
        drain_results();
        set_noise(NOISE_MAX, '0);
        send_sample(127);
        send_sample(-128);
        send_sample(-1);
        send_sample(0);

        // variance is zero now, so zero process noise leaves a zero divisor
        drain_results();
        set_noise('0, '0);
        send_sample(127);
        send_sample(-128);
        send_sample(3);

        drain_results();
        set_noise('0, NOISE_MAX);
        send_sample(100);
        send_sample(-100);

        drain_results();
        set_noise(NOISE_MAX, VAR_W'(1));
        send_sample(-128);
        send_sample(127);
        send_sample(-90);
        send_sample(-40);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            set_noise(pick_noise(), pick_noise());
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            random_samples(PHASE_ITEMS);
        end

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("checked %0d smoothed results from %0d samples under %0d noise settings",
                 checked, samples_sent, noise_sets);
        $display("flow control: none, sender gaps, receiver stalls, and both together");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rks_pkg.sv
src/rks_ser_mul.sv
src/rssi_kalman_smoother.sv
dv/rks_checker.sv
dv/testbench.sv
